// ===== hw/rtl/char_lcd_write_sequencer_unit_defines.svh =====
// Assertion macros shared by the character LCD write sequencer RTL.
// Depends on nothing; the asserting module must provide i_clk and i_rst_n.
`ifndef CHAR_LCD_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_UNIT_DEFINES_SVH

// A property checked on every rising clock edge outside reset.
`define CLWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// An implication checked on every rising clock edge outside reset.
`define CLWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A next-cycle implication checked outside reset.
`define CLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/clws_pkg.sv =====
// Package for the character LCD write sequencer: request, pin state and job types.
// Depends on nothing; used by every module of the block.
package clws_pkg;

    localparam logic [1:0] CMD_INSTR  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;

    localparam logic CFG_IDX_BUS_WIDTH = 1'b0;
    localparam logic CFG_IDX_LANE      = 1'b1;

    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
    localparam logic [7:0] LANE_UPPER_MASK = 8'hF0;
    localparam logic [7:0] LANE_LOWER_MASK = 8'h0F;

    localparam logic [2:0] STEP_LAST_BYTE   = 3'd3;
    localparam logic [2:0] STEP_LAST_NIBBLE = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
        logic [1:0] row;
        logic [3:0] col;
    } t_lcd_req;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [7:0] data_bus;
        logic       last;
    } t_pin_state;

    typedef struct packed {
        logic       bus_width_mode;
        logic       nibble_lane;
    } t_cfg_regs;

    typedef struct packed {
        logic       skip;
        logic       rs;
        logic [7:0] byte_val;
    } t_job;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h10;
            default: base = 8'h50;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] put_nibble(input logic [7:0] bus, input logic [3:0] nib,
                                              input logic lane);
        logic [7:0] res;
        if (lane) begin
            res = (bus & LANE_UPPER_MASK) | {4'h0, nib};
        end else begin
            res = (bus & LANE_LOWER_MASK) | {nib, 4'h0};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_write_sequencer_unit.sv =====
// Top level of the character LCD write sequencer: request register, config registers.
// Depends on clws_pkg, clws_decode and clws_seq.
//
// Usage: a write request (cmd, value, row, col) enters on the input channel and is
// accepted when i_in_valid is high and o_in_stall is low. Each request is expanded
// into a run of LCD pin states on the output channel, one per cycle while the output
// is not stalled, taken when o_out_valid is high and i_out_stall is low. An eight-bit
// write gives four states and a four-bit write seven; the final state carries last.
// An unused command code gives no states. The accepted request is registered, and
// its first state is then registered in the output register. One request is held
// while its states are produced, and the next is accepted in the cycle the final
// state is loaded into the output register. A stall on the output holds the output
// register and the sequencer, and back-pressures the input channel.
// The two config registers are written through i_cfg_valid / o_cfg_ready, which is
// always ready, and must only be written while the block is idle.
// Reset clears the config registers, the pin latches and all valid flags.
module char_lcd_write_sequencer_unit
    import clws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_lcd_req   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_pin_state o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data
);

    logic      r_in_valid;
    t_lcd_req  r_in;
    t_cfg_regs r_cfg;
    t_job      job;
    logic      job_done;
    logic      in_ready;

    assign in_ready    = !r_in_valid || job_done;
    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cfg      <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_IDX_BUS_WIDTH: r_cfg.bus_width_mode <= i_cfg_data;
                    CFG_IDX_LANE:      r_cfg.nibble_lane    <= i_cfg_data;
                    default:           r_cfg                <= r_cfg;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    clws_decode u_decode (
        .i_req (r_in),
        .o_job (job)
    );

    clws_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (r_in_valid),
        .i_job       (job),
        .o_job_done  (job_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/clws_decode.sv =====
// Command decoder: turns a request into the register select, bus byte and skip bit.
// Depends on clws_pkg.
module clws_decode
    import clws_pkg::*;
(
    input  t_lcd_req i_req,
    output t_job     o_job
);

    always_comb begin
        o_job.skip     = 1'b0;
        o_job.rs       = 1'b0;
        o_job.byte_val = i_req.value;
        unique case (i_req.cmd)
            CMD_INSTR: begin
                o_job.rs = 1'b0;
            end
            CMD_DATA: begin
                o_job.rs = 1'b1;
            end
            CMD_CURSOR: begin
                o_job.byte_val = SET_DDRAM_ADDR | (row_base(i_req.row) + {4'h0, i_req.col});
            end
            default: begin
                o_job.skip = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/clws_seq.sv =====
// Pin state sequencer: pin latches, step counter and the registered output stage.
// Depends on clws_pkg and char_lcd_write_sequencer_unit_defines.svh.
`include "char_lcd_write_sequencer_unit_defines.svh"

module clws_seq
    import clws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_regs  i_cfg,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_done,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_pin_state o_out_data
);

    logic       r_sel;
    logic       r_en;
    logic [7:0] r_bus;
    logic [2:0] r_step;
    logic       r_out_valid;
    t_pin_state r_out;

    logic       n_sel;
    logic       n_en;
    logic [7:0] n_bus;
    logic [2:0] n_step;
    logic       out_free;
    logic       load;
    logic       last_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_step = i_cfg.bus_width_mode ? (r_step == STEP_LAST_NIBBLE)
                                            : (r_step == STEP_LAST_BYTE);
    assign load       = i_job_valid && out_free && !i_job.skip;
    assign o_job_done = i_job_valid && out_free && (i_job.skip || last_step);

    always_comb begin
        n_sel = r_sel;
        n_en  = r_en;
        n_bus = r_bus;
        case (r_step)
            3'd0: n_sel = i_job.rs;
            3'd1: n_en  = 1'b1;
            3'd2: begin
                if (i_cfg.bus_width_mode) begin
                    n_bus = put_nibble(r_bus, i_job.byte_val[7:4], i_cfg.nibble_lane);
                end else begin
                    n_bus = i_job.byte_val;
                end
            end
            3'd3: n_en  = 1'b0;
            3'd4: n_en  = 1'b1;
            3'd5: n_bus = put_nibble(r_bus, i_job.byte_val[3:0], i_cfg.nibble_lane);
            3'd6: n_en  = 1'b0;
            default: n_en = r_en;
        endcase
        n_step = last_step ? 3'd0 : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_en        <= 1'b0;
            r_bus       <= 8'h00;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= load;
            end
            if (load) begin
                r_sel  <= n_sel;
                r_en   <= n_en;
                r_bus  <= n_bus;
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.reg_select <= n_sel;
            r_out.read_write <= 1'b0;
            r_out.enable     <= n_en;
            r_out.data_bus   <= n_bus;
            r_out.last       <= last_step;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CLWS_ASSERT(a_step_range, r_step <= STEP_LAST_NIBBLE, "Step counter out of range.")
    `CLWS_ASSERT_IMP(a_last_e_low, r_out_valid && r_out.last, !r_out.enable,
                     "Write ended with E high.")
    `CLWS_ASSERT_NEXT(a_done_resets_step, o_job_done, r_step == 3'd0,
                      "Step not cleared after a write.")
    `CLWS_ASSERT_IMP(a_done_idle_e, o_job_done, n_en == 1'b0 || i_job.skip,
                     "E left high between writes.")

endmodule

// ===== tb/sv/tb_char_lcd_write_sequencer_unit.sv =====
// Self-checking testbench for the character LCD write sequencer unit.
// A scoreboard class predicts the pin-state run of every accepted request and
// checks each pin state taken from the block. Depends on clws_pkg and the block.
`timescale 1ns / 100ps

module tb_char_lcd_write_sequencer_unit
    import clws_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class lcd_pin_scoreboard;
        bit          nibble_mode;
        bit          lower_lane;
        logic [7:0]  bus_pin;
        logic        en_pin;
        logic        rs_pin;
        t_pin_state  pin_states_q[$];
        int          errors;

        function new();
            nibble_mode = 1'b0;
            lower_lane = 1'b0;
            bus_pin = 8'h00;
            en_pin = 1'b0;
            rs_pin = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic val);
            if (idx == CFG_IDX_BUS_WIDTH) begin
                nibble_mode = val;
            end else begin
                lower_lane = val;
            end
        endfunction

        function void push_state(bit is_last);
            t_pin_state ps;
            ps.reg_select = rs_pin;
            ps.read_write = 1'b0;
            ps.enable = en_pin;
            ps.data_bus = bus_pin;
            ps.last = is_last;
            pin_states_q.push_back(ps);
        endfunction

        function void load_nibble(logic [3:0] nib);
            if (lower_lane) begin
                bus_pin = (bus_pin & LANE_UPPER_MASK) | {4'h0, nib};
            end else begin
                bus_pin = (bus_pin & LANE_LOWER_MASK) | {nib, 4'h0};
            end
        endfunction

        function void note_request(t_lcd_req req);
            logic [7:0] code;
            logic [7:0] offset;
            if (req.cmd == CMD_UNUSED) begin
                return;
            end
            if (req.cmd == CMD_CURSOR) begin
                case (req.row)
                    2'd0: offset = 8'h00;
                    2'd1: offset = 8'h40;
                    2'd2: offset = 8'h10;
                    default: offset = 8'h50;
                endcase
                code = SET_DDRAM_ADDR | (offset + {4'h0, req.col});
                rs_pin = 1'b0;
            end else begin
                code = req.value;
                rs_pin = (req.cmd == CMD_DATA);
            end
            push_state(1'b0);
            en_pin = 1'b1;
            push_state(1'b0);
            if (nibble_mode) begin
                load_nibble(code[7:4]);
                push_state(1'b0);
                en_pin = 1'b0;
                push_state(1'b0);
                en_pin = 1'b1;
                push_state(1'b0);
                load_nibble(code[3:0]);
                push_state(1'b0);
                en_pin = 1'b0;
                push_state(1'b1);
            end else begin
                bus_pin = code;
                push_state(1'b0);
                en_pin = 1'b0;
                push_state(1'b1);
            end
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_pin_state got);
            t_pin_state exp_ps;
            if (pin_states_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected pin state, expected none, got %p", $time, got);
                return;
            end
            exp_ps = pin_states_q.pop_front();
            compare_field("reg_select", 8'(exp_ps.reg_select), 8'(got.reg_select));
            compare_field("read_write", 8'(exp_ps.read_write), 8'(got.read_write));
            compare_field("enable", 8'(exp_ps.enable), 8'(got.enable));
            compare_field("data_bus", exp_ps.data_bus, got.data_bus);
            compare_field("last", 8'(exp_ps.last), 8'(got.last));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       o_in_stall;
    t_lcd_req   in_data;
    logic       o_out_valid;
    logic       out_stall;
    t_pin_state o_out_data;
    logic       cfg_valid;
    logic       o_cfg_ready;
    logic       cfg_index;
    logic       cfg_data;

    lcd_pin_scoreboard sb;
    bit                tx_idle;
    bit                rx_idle;

    char_lcd_write_sequencer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_request(input t_lcd_req req);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic send_fields(input logic [1:0] cmd, input logic [7:0] value,
                               input logic [1:0] row, input logic [3:0] col);
        send_request(t_lcd_req'{cmd: cmd, value: value, row: row, col: col});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pin_states_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(input logic mode, input logic lane);
        drain();
        write_reg(CFG_IDX_BUS_WIDTH, mode);
        write_reg(CFG_IDX_LANE, lane);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_lcd_req random_request();
        t_lcd_req req;
        req.cmd = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
        req.value = 8'($urandom);
        req.row = 2'($urandom);
        req.col = 4'($urandom);
        return req;
    endfunction

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_out_data);
        end
    end

    initial begin
        logic modes [7];
        logic lanes [7];
        sb = new();
        modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        lanes = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDX_BUS_WIDTH;
        cfg_data <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Eight-bit mode with the lower lane selected, which must make no difference.
        apply_setting(1'b0, 1'b1);
        send_fields(CMD_INSTR, 8'h00, 2'd0, 4'd0);
        send_fields(CMD_INSTR, 8'hFF, 2'd0, 4'd0);
        send_fields(CMD_DATA, 8'h00, 2'd0, 4'd0);
        send_fields(CMD_DATA, 8'hFF, 2'd3, 4'd15);
        send_fields(CMD_DATA, 8'hA5, 2'd0, 4'd0);
        send_fields(CMD_CURSOR, 8'h00, 2'd0, 4'd0);
        send_fields(CMD_CURSOR, 8'h00, 2'd3, 4'd15);
        send_fields(CMD_CURSOR, 8'hFF, 2'd1, 4'd15);
        send_fields(CMD_CURSOR, 8'hFF, 2'd2, 4'd0);
        send_fields(CMD_INSTR, 8'h5A, 2'd3, 4'd15);
        send_fields(CMD_UNUSED, 8'hFF, 2'd3, 4'd15);

        apply_setting(1'b1, 1'b0);
        send_fields(CMD_DATA, 8'hFF, 2'd0, 4'd0);
        send_fields(CMD_INSTR, 8'h00, 2'd0, 4'd0);
        send_fields(CMD_CURSOR, 8'h00, 2'd3, 4'd15);
        send_fields(CMD_DATA, 8'h3C, 2'd1, 4'd7);
        send_fields(CMD_UNUSED, 8'h00, 2'd0, 4'd0);
        send_fields(CMD_DATA, 8'hC3, 2'd0, 4'd0);

        apply_setting(1'b1, 1'b1);
        send_fields(CMD_DATA, 8'h96, 2'd0, 4'd0);
        send_fields(CMD_INSTR, 8'h01, 2'd0, 4'd0);
        send_fields(CMD_CURSOR, 8'h00, 2'd2, 4'd7);

        for (int p = 0; p < 7; p++) begin
            apply_setting(modes[p], lanes[p]);
            tx_idle = (p % 3 != 2);
            rx_idle = (p % 4 != 1);
            for (int n = 0; n < 37; n++) begin
                send_request(random_request());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pin_states_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/clws_pkg.sv
hw/rtl/clws_decode.sv
hw/rtl/clws_seq.sv
hw/rtl/char_lcd_write_sequencer_unit.sv
tb/sv/tb_char_lcd_write_sequencer_unit.sv
